// ===== sv/polyline_nearest_projection_unit_defines.svh =====
// Assertion macros for the polyline nearest projection unit.
`ifndef POLYLINE_NEAREST_PROJECTION_UNIT_DEFINES_SVH
`define POLYLINE_NEAREST_PROJECTION_UNIT_DEFINES_SVH

// same-cycle implication
`define PNP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pnp_pkg.sv =====
// Package: widths, codes and sequencer states of the polyline projection unit.
package pnp_pkg;

    localparam int MAX_NODES  = 64;
    localparam int COORD_BITS = 16;
    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int NODE_W     = 3 * COORD_BITS;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int AB_W       = COORD_BITS + 1;
    localparam int LSQ_W      = 2 * AB_W + 1;
    localparam int DOT_W      = 2 * AB_W + 4;
    localparam int MUL_W      = 27;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int Q_W        = 17;
    localparam int DIVN_W     = 54;
    localparam int DIVD_W     = 36;
    localparam int SQV_W      = 52;
    localparam int SQR_W      = SQV_W / 2;
    localparam int LEN_W      = 25;
    localparam int TOT_W      = 31;
    localparam int CUM_W      = 48;
    localparam int D_W        = 26;
    localparam int DSQ_W      = 51;
    localparam int PROJ_W     = 24;
    localparam int SEG_W      = 6;
    localparam int FRAC_W     = 16;
    localparam int DIST_W     = 34;
    localparam int IN_W       = NODE_W;
    localparam int OUT_W      = 3 * PROJ_W + SEG_W + 2 * FRAC_W + DIST_W;

    localparam logic [Q_W-1:0] T_HALF = Q_W'(32768);
    localparam logic [Q_W-1:0] T_ONE  = Q_W'(65536);
    localparam logic [Q_W-1:0] T_MAX  = Q_W'(65535);

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDA, ST_RDB, ST_LDB, ST_MAC, ST_TQ, ST_DIV, ST_PMUL,
        ST_PD, ST_PSQ, ST_PACC, ST_WAITL, ST_FMUL, ST_FACC, ST_FDIV, ST_DONE
    } t_state;

endpackage

// ===== sv/pnp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pnp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pnp_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known below 2^Q_W.
module pnp_div
    import pnp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_num,
    input  logic [DIVD_W-1:0] i_den,
    output logic              o_busy,
    output logic [Q_W-1:0]    o_quot
);

    localparam int DIVC_W = $clog2(Q_W);

    logic              r_busy;
    logic [DIVC_W-1:0] r_cnt;
    logic [DIVD_W:0]   r_rem;
    logic [Q_W-1:0]    r_lo;
    logic [DIVD_W-1:0] r_den;
    logic [Q_W-1:0]    r_quot;
    logic [DIVD_W:0]   w_shift;
    logic              w_ge;

    assign w_shift = {r_rem[DIVD_W-1:0], r_lo[Q_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[DIVN_W-1:Q_W];
            r_lo   <= i_num[Q_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
            r_cnt  <= DIVC_W'(Q_W - 1);
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quot <= {r_quot[Q_W-2:0], w_ge};
            r_lo   <= {r_lo[Q_W-2:0], 1'b0};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== sv/pnp_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module pnp_sqrt
    import pnp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQV_W-1:0] i_val,
    output logic             o_busy,
    output logic [SQR_W-1:0] o_root
);

    localparam int SQC_W = $clog2(SQR_W);

    logic             r_busy;
    logic [SQC_W-1:0] r_cnt;
    logic [SQV_W-1:0] r_v;
    logic [SQR_W:0]   r_rem;
    logic [SQR_W-1:0] r_root;
    logic [SQR_W+2:0] w_rem;
    logic [SQR_W+2:0] w_trial;
    logic             w_ge;

    assign w_rem   = {r_rem, r_v[SQV_W-1:SQV_W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_rem >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= SQC_W'(SQR_W - 1);
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_rem[SQR_W:0] - w_trial[SQR_W:0]) : w_rem[SQR_W:0];
            r_root <= {r_root[SQR_W-2:0], w_ge};
            r_v    <= {r_v[SQV_W-3:0], 2'b00};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== sv/polyline_nearest_projection_unit.sv =====
// Polyline nearest projection unit: node store, sequencer and shared datapath.
// A clear, an append, an error or an unused request code goes straight to the done
// state and presents its result through the output register. A query walks the stored
// segments one at a time (two node reads, six products on the shared 27x27 multiplier,
// the projection and distance products, with the square root for the segment length
// running alongside, and the divider when the projection needs it), then, for a line of
// nonzero length, runs the arc-length division before the result is presented. The
// input side takes a new transfer only while the sequencer is idle; one finished result
// may wait in the output register while the next item runs.
module polyline_nearest_projection_unit
    import pnp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,  // coord_x, coord_y, coord_z
    input  logic [REQ_W-1:0]  i_s_tuser,  // req_type
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,  // proj_x, proj_y, proj_z, segment_index,
                                          // seg_fraction, line_fraction, distance_sq
    output logic [STAT_W-1:0] o_m_tuser   // status
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]         r_count;
    logic [ADDR_W-1:0]        r_seg;
    logic signed [COORD_BITS-1:0] r_p [3];
    logic signed [COORD_BITS-1:0] r_a [3];
    logic signed [AB_W-1:0]   r_ab [3];
    logic signed [AB_W-1:0]   r_pa [3];
    logic [2:0]               r_k;
    logic [1:0]               r_ax;
    logic [LSQ_W-1:0]         r_lsq;
    logic signed [DOT_W-1:0]  r_dot;
    logic [Q_W-1:0]           r_tq;
    logic signed [PROJ_W-1:0] r_to [3];
    logic signed [D_W-1:0]    r_d;
    logic [DSQ_W-1:0]         r_dsq;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_best_valid;
    logic [DSQ_W-1:0]         r_best_dsq;
    logic signed [PROJ_W-1:0] r_best_to [3];
    logic [ADDR_W-1:0]        r_best_seg;
    logic [Q_W-1:0]           r_best_t;
    logic [TOT_W-1:0]         r_best_cum;
    logic [LEN_W-1:0]         r_best_len;
    logic [TOT_W-1:0]         r_total;
    logic [Q_W-1:0]           r_lf;
    t_status                  r_res_status;
    logic                     r_res_zero;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_tdata;
    logic [STAT_W-1:0]        r_out_tuser;

    logic                     w_in_fire;
    logic                     w_full;
    logic                     w_more;
    logic                     w_need_div;
    logic                     w_load_out;
    logic                     w_better;
    logic                     w_ram_we;
    logic [ADDR_W-1:0]        w_ram_raddr;
    logic [NODE_W-1:0]        w_ram_rdata;
    logic signed [COORD_BITS-1:0] w_rd [3];
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic                     w_div_start, w_div_busy;
    logic [DIVN_W-1:0]        w_div_num;
    logic [DIVD_W-1:0]        w_div_den;
    logic [Q_W-1:0]           w_div_quot;
    logic                     w_sq_start, w_sq_busy;
    logic [SQR_W-1:0]         w_sq_root;
    logic [LEN_W-1:0]         w_len;
    logic [CUM_W-1:0]         w_cum;
    logic signed [PROD_W-1:0] w_rnd, w_to_full, w_d_full;
    logic [FRAC_W-1:0]        w_sf, w_lf;
    logic [DIST_W-1:0]        w_dist;

    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_full     = r_count >= CNT_W'(MAX_NODES);
    assign w_more     = ({1'b0, r_seg} + CNT_W'(2)) < r_count;
    assign w_need_div = (r_lsq != '0) && !r_dot[DOT_W-1] && (r_dot != '0)
                        && ($unsigned(r_dot) < DOT_W'(r_lsq));
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);
    assign w_len      = LEN_W'(w_sq_root);
    assign w_better   = !r_best_valid || (r_dsq < r_best_dsq);
    assign w_cum      = (CUM_W'(r_best_cum) << 16) + CUM_W'(r_prod);

    assign w_rd[0] = $signed(w_ram_rdata[COORD_BITS-1:0]);
    assign w_rd[1] = $signed(w_ram_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign w_rd[2] = $signed(w_ram_rdata[3*COORD_BITS-1:2*COORD_BITS]);

    assign w_rnd     = (r_prod + $signed(PROD_W'(128))) >>> 8;
    assign w_to_full = (PROD_W'(r_a[r_ax]) <<< 8) + w_rnd;
    assign w_d_full  = (PROD_W'(r_p[r_ax]) <<< 8) - w_to_full;

    assign w_sf   = (r_best_t > T_MAX) ? FRAC_W'(T_MAX) : FRAC_W'(r_best_t);
    assign w_lf   = (r_lf > T_MAX) ? FRAC_W'(T_MAX) : FRAC_W'(r_lf);
    assign w_dist = DIST_W'((r_best_dsq + DSQ_W'(32768)) >> 16);

    pnp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_s_tdata[NODE_W-1:0]),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    pnp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_div_quot)
    );

    pnp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (SQV_W'({r_lsq, 16'b0})),
        .o_busy  (w_sq_busy),
        .o_root  (w_sq_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (t_req'(i_s_tuser) == REQ_QUERY && r_count >= CNT_W'(2)) begin
                        n_state = ST_RDA;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RDA:  n_state = ST_RDB;
            ST_RDB:  n_state = ST_LDB;
            ST_LDB:  n_state = ST_MAC;
            ST_MAC:  n_state = (r_k == 3'd6) ? ST_TQ : ST_MAC;
            ST_TQ:   n_state = w_need_div ? ST_DIV : ST_PMUL;
            ST_DIV:  n_state = w_div_busy ? ST_DIV : ST_PMUL;
            ST_PMUL: n_state = ST_PD;
            ST_PD:   n_state = ST_PSQ;
            ST_PSQ:  n_state = (r_ax == 2'd2) ? ST_PACC : ST_PMUL;
            ST_PACC: n_state = ST_WAITL;
            ST_WAITL: begin
                if (!w_sq_busy) begin
                    n_state = w_more ? ST_RDA : ST_FMUL;
                end
            end
            ST_FMUL: n_state = ST_FACC;
            ST_FACC: n_state = (r_total == '0) ? ST_DONE : ST_FDIV;
            ST_FDIV: n_state = w_div_busy ? ST_FDIV : ST_DONE;
            ST_DONE: n_state = w_load_out ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        w_ram_we    = 1'b0;
        w_ram_raddr = r_seg;
        w_div_start = 1'b0;
        w_div_num   = (DIVN_W'(r_dot) << 17) + DIVN_W'(r_lsq);
        w_div_den   = DIVD_W'({r_lsq, 1'b0});
        w_sq_start  = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_ram_we = i_s_tvalid && t_req'(i_s_tuser) == REQ_APPEND && !w_full;
            end
            ST_RDB: w_ram_raddr = r_seg + 1'b1;
            ST_MAC: begin
                unique case (r_k)
                    3'd0: begin w_mul_a = MUL_W'(r_ab[0]); w_mul_b = MUL_W'(r_ab[0]); end
                    3'd1: begin w_mul_a = MUL_W'(r_ab[1]); w_mul_b = MUL_W'(r_ab[1]); end
                    3'd2: begin w_mul_a = MUL_W'(r_ab[2]); w_mul_b = MUL_W'(r_ab[2]); end
                    3'd3: begin w_mul_a = MUL_W'(r_pa[0]); w_mul_b = MUL_W'(r_ab[0]); end
                    3'd4: begin w_mul_a = MUL_W'(r_pa[1]); w_mul_b = MUL_W'(r_ab[1]); end
                    3'd5: begin w_mul_a = MUL_W'(r_pa[2]); w_mul_b = MUL_W'(r_ab[2]); end
                    default: begin w_mul_a = '0; w_mul_b = '0; end
                endcase
            end
            ST_TQ: begin
                w_div_start = w_need_div;
                w_sq_start  = 1'b1;
            end
            ST_PMUL: begin
                w_mul_a = MUL_W'(r_ab[r_ax]);
                w_mul_b = MUL_W'($signed({1'b0, r_tq}));
            end
            ST_PSQ: begin
                w_mul_a = MUL_W'(r_d);
                w_mul_b = MUL_W'(r_d);
            end
            ST_FMUL: begin
                w_mul_a = MUL_W'($signed({1'b0, r_best_t}));
                w_mul_b = MUL_W'($signed({1'b0, r_best_len}));
            end
            ST_FACC: begin
                w_div_start = (r_total != '0);
                w_div_num   = DIVN_W'({w_cum, 1'b0}) + DIVN_W'(r_total);
                w_div_den   = DIVD_W'({r_total, 1'b0});
            end
            default: begin
                w_ram_raddr = r_seg;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_fire) begin
                unique case (t_req'(i_s_tuser))
                    REQ_CLEAR:  r_count <= '0;
                    REQ_APPEND: if (!w_full) r_count <= r_count + 1'b1;
                    default:    r_count <= r_count;
                endcase
                r_best_valid <= 1'b0;
            end
            if (r_state == ST_WAITL && !w_sq_busy && w_better) begin
                r_best_valid <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    r_p[0]       <= $signed(i_s_tdata[COORD_BITS-1:0]);
                    r_p[1]       <= $signed(i_s_tdata[2*COORD_BITS-1:COORD_BITS]);
                    r_p[2]       <= $signed(i_s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
                    r_seg        <= '0;
                    r_total      <= '0;
                    unique case (t_req'(i_s_tuser))
                        REQ_APPEND: begin
                            r_res_zero   <= 1'b1;
                            r_res_status <= w_full ? STAT_FULL : STAT_OK;
                        end
                        REQ_QUERY: begin
                            r_res_zero   <= (r_count < CNT_W'(2));
                            r_res_status <= (r_count < CNT_W'(2)) ? STAT_FEW : STAT_OK;
                        end
                        default: begin
                            r_res_zero   <= 1'b1;
                            r_res_status <= STAT_OK;
                        end
                    endcase
                end
            end
            ST_RDB: begin
                for (int i = 0; i < 3; i++) begin
                    r_a[i]  <= w_rd[i];
                    r_pa[i] <= AB_W'(r_p[i]) - AB_W'(w_rd[i]);
                end
            end
            ST_LDB: begin
                for (int i = 0; i < 3; i++) begin
                    r_ab[i] <= AB_W'(w_rd[i]) - AB_W'(r_a[i]);
                end
                r_lsq <= '0;
                r_dot <= '0;
                r_k   <= '0;
            end
            ST_MAC: begin
                r_k <= r_k + 1'b1;
                if (r_k >= 3'd1 && r_k <= 3'd3) begin
                    r_lsq <= r_lsq + LSQ_W'(r_prod);
                end else if (r_k >= 3'd4) begin
                    r_dot <= r_dot + DOT_W'(r_prod);
                end
            end
            ST_TQ: begin
                r_dsq <= '0;
                r_ax  <= '0;
                if (r_lsq == '0) begin
                    r_tq <= T_HALF;
                end else if (r_dot[DOT_W-1] || r_dot == '0) begin
                    r_tq <= '0;
                end else begin
                    r_tq <= T_ONE;
                end
            end
            ST_DIV: begin
                if (!w_div_busy) begin
                    r_tq <= w_div_quot;
                end
            end
            ST_PMUL: begin
                if (r_ax != 2'd0) begin
                    r_dsq <= r_dsq + DSQ_W'(r_prod);
                end
            end
            ST_PD: begin
                r_to[r_ax] <= PROJ_W'(w_to_full);
                r_d        <= D_W'(w_d_full);
            end
            ST_PSQ: begin
                r_ax <= r_ax + 1'b1;
            end
            ST_PACC: begin
                r_dsq <= r_dsq + DSQ_W'(r_prod);
            end
            ST_WAITL: begin
                if (!w_sq_busy) begin
                    if (w_better) begin
                        r_best_dsq <= r_dsq;
                        r_best_to  <= r_to;
                        r_best_seg <= r_seg;
                        r_best_t   <= r_tq;
                        r_best_cum <= r_total;
                        r_best_len <= w_len;
                    end
                    r_total <= r_total + TOT_W'(w_len);
                    r_seg   <= r_seg + 1'b1;
                end
            end
            ST_FACC: begin
                r_lf <= '0;
            end
            ST_FDIV: begin
                if (!w_div_busy) begin
                    r_lf <= w_div_quot;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    r_out_tuser <= r_res_status;
                    if (r_res_zero) begin
                        r_out_tdata <= '0;
                    end else begin
                        r_out_tdata <= {w_dist, w_lf, w_sf, SEG_W'(r_best_seg),
                                        r_best_to[2], r_best_to[1], r_best_to[0]};
                    end
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

// ===== sv/pnp_checker.sv =====
// Port-level checker for the polyline nearest projection unit, with its bind.
`include "polyline_nearest_projection_unit_defines.svh"

module pnp_checker
    import pnp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [IN_W-1:0]   i_s_tdata,
    input logic [REQ_W-1:0]  i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_W-1:0]  o_m_tdata,
    input logic [STAT_W-1:0] o_m_tuser
);

    `PNP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    `PNP_ASSERT_NOW(a_status_code, o_m_tvalid,
        o_m_tuser == STAT_OK || o_m_tuser == STAT_FEW || o_m_tuser == STAT_FULL,
        "status code out of range")

    `PNP_ASSERT_NOW(a_err_zero, o_m_tvalid && o_m_tuser != STAT_OK, o_m_tdata == '0,
        "error result carries nonzero data")

    `PNP_ASSERT_NEXT(a_busy_after, i_s_tvalid && o_s_tready, !o_s_tready,
        "input ready right after a transfer")

endmodule

bind polyline_nearest_projection_unit pnp_checker u_pnp_checker (.*);

// ===== dv/polyline_nearest_projection_unit_tb.sv =====
// Self-checking testbench for the polyline nearest projection unit.
`timescale 1ns / 1ps

module polyline_nearest_projection_unit_tb;
    import pnp_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    typedef struct {
        t_req              req;
        logic signed [15:0] cx, cy, cz;
    } t_req_item;

    typedef struct {
        t_status            status;
        logic [PROJ_W-1:0] px, py, pz;
        logic [SEG_W-1:0]  seg;
        logic [FRAC_W-1:0] sfrac, lfrac;
        logic [DIST_W-1:0] dsq;
    } t_proj_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata;   // coord_x, coord_y, coord_z
    logic [REQ_W-1:0]  i_s_tuser;   // req_type
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;   // proj_x, proj_y, proj_z, segment_index,
                                    // seg_fraction, line_fraction, distance_sq
    logic [STAT_W-1:0] o_m_tuser;   // status

    polyline_nearest_projection_unit dut (.*);

    t_req_item    pending_items[$];
    t_proj_result expected_results[$];
    longint       line_nodes[MAX_NODES][3];
    int           line_count = 0;
    int           error_count = 0;
    int           results_seen = 0;
    int           queries_ok = 0;
    int           burst_left;
    int           gap_left;
    int           hold_left;
    bit           stim_done;
    bit           long_hold_req;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
        return q;
    endfunction

    function automatic longint round_div(longint n, longint d);
        return floor_div(2 * n + d, 2 * d);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic t_proj_result project_nearest(longint pt[3]);
        t_proj_result res;
        longint best, best_t, tq, lsq, dot, d, dsq, l, total, cum, lf;
        longint ab[3], to_p[3], best_p[3];
        int best_seg;
        res = '{STAT_OK, 0, 0, 0, 0, 0, 0, 0};
        best = -1;
        best_seg = 0;
        best_t = 0;
        best_p = '{0, 0, 0};
        for (int i = 0; i + 1 < line_count; i++) begin
            lsq = 0;
            dot = 0;
            for (int k = 0; k < 3; k++) begin
                ab[k] = line_nodes[i+1][k] - line_nodes[i][k];
                lsq += ab[k] * ab[k];
                dot += (pt[k] - line_nodes[i][k]) * ab[k];
            end
            tq = (lsq == 0) ? 32768 : round_div(dot * 65536, lsq);
            dsq = 0;
            for (int k = 0; k < 3; k++) begin
                if (tq < 1) to_p[k] = line_nodes[i][k] * 256;
                else if (tq > 65535) to_p[k] = line_nodes[i+1][k] * 256;
                else to_p[k] = line_nodes[i][k] * 256 + round_div(ab[k] * tq, 256);
                d = pt[k] * 256 - to_p[k];
                dsq += d * d;
            end
            if (best < 0 || dsq < best) begin
                best = dsq;
                best_p = to_p;
                best_seg = i;
                best_t = tq < 0 ? 0 : (tq > 65536 ? 65536 : tq);
            end
        end
        total = 0;
        cum = 0;
        for (int i = 0; i + 1 < line_count; i++) begin
            lsq = 0;
            for (int k = 0; k < 3; k++) begin
                d = line_nodes[i+1][k] - line_nodes[i][k];
                lsq += d * d;
            end
            l = int_sqrt(lsq << 16);
            total += l;
            if (i < best_seg) cum += l << 16;
            else if (i == best_seg) cum += best_t * l;
        end
        if (total == 0) lf = 0;
        else begin
            lf = round_div(cum, total);
            if (lf > 65535) lf = 65535;
        end
        res.px = best_p[0][PROJ_W-1:0];
        res.py = best_p[1][PROJ_W-1:0];
        res.pz = best_p[2][PROJ_W-1:0];
        res.seg = best_seg[SEG_W-1:0];
        res.sfrac = (best_t > 65535) ? 16'hFFFF : best_t[15:0];
        res.lfrac = lf[15:0];
        res.dsq = 34'((best + 32768) >> 16);
        return res;
    endfunction

    function automatic t_proj_result apply_request(t_req_item it);
        t_proj_result res;
        longint pt[3];
        res = '{STAT_OK, 0, 0, 0, 0, 0, 0, 0};
        pt = '{longint'(it.cx), longint'(it.cy), longint'(it.cz)};
        case (it.req)
            REQ_CLEAR: begin
                line_count = 0;
            end
            REQ_APPEND: begin
                if (line_count >= MAX_NODES) res.status = STAT_FULL;
                else begin
                    line_nodes[line_count] = pt;
                    line_count++;
                end
            end
            REQ_QUERY: begin
                if (line_count < 2) res.status = STAT_FEW;
                else begin
                    res = project_nearest(pt);
                    queries_ok++;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch %s at result %0d: got %0h want %0h", what, results_seen, got, want);
    endtask

    task automatic push_item(logic [1:0] req, int x, int y, int z);
        t_req_item it;
        it.req = t_req'(req);
        it.cx = x[15:0];
        it.cy = y[15:0];
        it.cz = z[15:0];
        pending_items.push_back(it);
    endtask

    function automatic int rand_coord(int span);
        if (span >= 32768) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
            i_s_tuser <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(apply_request(pending_items.pop_front()));
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 && stim_done) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser <= pending_items[0].req;
                i_s_tdata <= {pending_items[0].cz, pending_items[0].cy, pending_items[0].cx};
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left <= 0;
        end else if (long_hold_req && hold_left == 0) begin
            hold_left <= 3000;
            i_m_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= 0;
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_proj_result w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("unexpected result transfer %0d", results_seen);
            end else begin
                w = expected_results.pop_front();
                if (o_m_tuser !== w.status) report_mismatch("status", o_m_tuser, w.status);
                if (o_m_tdata[23:0] !== w.px) report_mismatch("proj_x", o_m_tdata[23:0], w.px);
                if (o_m_tdata[47:24] !== w.py) report_mismatch("proj_y", o_m_tdata[47:24], w.py);
                if (o_m_tdata[71:48] !== w.pz) report_mismatch("proj_z", o_m_tdata[71:48], w.pz);
                if (o_m_tdata[77:72] !== w.seg) report_mismatch("segment", o_m_tdata[77:72], w.seg);
                if (o_m_tdata[93:78] !== w.sfrac)
                    report_mismatch("seg_fraction", o_m_tdata[93:78], w.sfrac);
                if (o_m_tdata[109:94] !== w.lfrac)
                    report_mismatch("line_fraction", o_m_tdata[109:94], w.lfrac);
                if (o_m_tdata[143:110] !== w.dsq)
                    report_mismatch("distance_sq", o_m_tdata[143:110], w.dsq);
            end
        end
    end

    initial begin
        int n, span, cnt;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        long_hold_req = 1'b0;

        // directed: errors, extremes, zero-length and zero-total lines
        push_item(REQ_QUERY, 0, 0, 0);
        push_item(REQ_APPEND, 5, 5, 5);
        push_item(REQ_QUERY, 1, 2, 3);
        push_item(REQ_APPEND, 5, 5, 5);
        push_item(REQ_QUERY, -32768, 32767, 0);
        push_item(REQ_SPARE, 32767, -1, 12345);
        push_item(REQ_CLEAR, -1, -1, -1);
        push_item(REQ_APPEND, -32768, -32768, -32768);
        push_item(REQ_APPEND, 32767, 32767, 32767);
        push_item(REQ_APPEND, 32767, -32768, 0);
        push_item(REQ_QUERY, 32767, 32767, 32767);
        push_item(REQ_QUERY, -32768, -32768, -32768);
        push_item(REQ_QUERY, 0, 0, 0);
        push_item(REQ_QUERY, 32767, -32768, -32768);
        push_item(REQ_QUERY, -1, 32767, 16384);
        push_item(REQ_CLEAR, 0, 0, 0);
        push_item(REQ_APPEND, 0, 0, 0);
        push_item(REQ_APPEND, 10, 0, 0);
        push_item(REQ_APPEND, 0, 0, 0);
        push_item(REQ_QUERY, 5, 3, 0);
        push_item(REQ_QUERY, 10, 7, 0);
        push_item(REQ_CLEAR, 0, 0, 0);
        for (int i = 0; i < MAX_NODES; i++) push_item(REQ_APPEND, i * 3, -i, i & 1);
        push_item(REQ_APPEND, 1, 1, 1);
        push_item(REQ_QUERY, 40, -20, 7);

        // random: short lines with queries, some noise, rare long lines
        n = 0;
        while (n < 660) begin
            push_item(REQ_CLEAR, rand_coord(32768), rand_coord(32768), rand_coord(32768));
            n++;
            span = ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(1, 300);
            cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 66) : $urandom_range(0, 5);
            for (int i = 0; i < cnt; i++) begin
                push_item(REQ_APPEND, rand_coord(span), rand_coord(span), rand_coord(span));
                n++;
            end
            for (int i = $urandom_range(1, 6); i > 0; i--) begin
                case ($urandom_range(0, 9))
                    0: push_item(REQ_SPARE, rand_coord(32768), rand_coord(32768),
                                 rand_coord(32768));
                    1: push_item(REQ_APPEND, rand_coord(span), rand_coord(span), rand_coord(span));
                    default: push_item(REQ_QUERY, rand_coord(span), rand_coord(span),
                                       rand_coord(span));
                endcase
                n++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stim_done <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold_req <= 1'b1;
        @(posedge i_clk);
        long_hold_req <= 1'b0;

        while (pending_items.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d result transfers, %0d successful queries on lines up to %0d nodes",
                 results_seen, queries_ok, MAX_NODES);
        $display("includes error statuses, unused codes, degenerate segments and a long stall");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
